[design/ott_pkg.sv]
// Package for the OBJ text tokenizer: scan modes, token kinds, the token record
// and small byte classifiers. No dependencies.
package ott_pkg;

    typedef enum logic [2:0] {
        MODE_BOUND   = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_VF      = 3'd2,
        MODE_DIGIT   = 3'd3,
        MODE_MINUS   = 3'd4,
        MODE_INVALID = 3'd5
    } t_mode;

    localparam logic [2:0] KIND_INVALID = 3'd0;
    localparam logic [2:0] KIND_COMMENT = 3'd1;
    localparam logic [2:0] KIND_SYMBOL  = 3'd2;
    localparam logic [2:0] KIND_FLOAT   = 3'd3;
    localparam logic [2:0] KIND_NUMBER  = 3'd4;
    localparam logic [2:0] KIND_SLASH   = 3'd5;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_F = 8'h66;
    localparam logic [7:0] CH_LOW_V = 8'h76;

    localparam int LINE_W = 24;
    localparam int COL_W  = 16;
    localparam int POS_W  = 32;
    localparam int LEN_W  = 16;

    typedef struct packed {
        logic [2:0]        kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  column;
        logic [POS_W-1:0]  offset;
        logic [LEN_W-1:0]  length;
    } t_token;

    // Space, tab, LF, VT, FF and CR.
    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

endpackage

[design/obj_text_tokenizer.sv]
// OBJ text tokenizer: one byte per request in, one token per request out. Depends on ott_pkg.
// A byte waits in the input register until the result buffer is empty or drains, then its
// tokens are registered into that buffer and offered on the result port, oldest first.
// Throughput: one byte per cycle while the result side does not stall; while both tokens of
// a byte are waiting, or a result stall holds a waiting token, the next byte is held.
// Reset: synchronous, active low; clears the scan state, the counters and both buffers.
module obj_text_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_token_kind,
    output logic [23:0] o_token_line,
    output logic [15:0] o_token_column,
    output logic [31:0] o_token_offset,
    output logic [15:0] o_token_length,
    output logic        o_last_of_item
);

    // Input register: decouples the upstream side from the result buffer.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Scan state and position counters.
    ott_pkg::t_mode r_mode, n_mode;
    logic [ott_pkg::LINE_W-1:0] r_line, n_line;
    logic [ott_pkg::COL_W-1:0]  r_col, n_col;
    logic [ott_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [ott_pkg::POS_W-1:0]  r_start_pos, n_start_pos;
    logic [ott_pkg::COL_W-1:0]  r_start_col, n_start_col;
    logic [ott_pkg::LEN_W-1:0]  r_run_len, n_run_len;
    logic [1:0]                 r_dots, n_dots;

    // Result buffer: up to two tokens from one byte, oldest in slot 0.
    ott_pkg::t_token r_tok0, r_tok1;
    logic [1:0]      r_cnt;

    logic in_acc, out_acc, move;
    logic at_bound, extend, end_v, slash_v, flush_v;
    logic [2:0] end_kind, flush_kind;
    logic ws;
    ott_pkg::t_token end_tok, slash_tok, flush_tok, slot0, slot1;
    logic [1:0] n_cnt;

    assign out_acc    = (r_cnt != 2'd0) && !i_out_stall;
    // A byte leaves the input register when the buffer is empty or drains this cycle.
    assign move       = r_in_valid && ((r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_acc));
    assign o_in_stall = r_in_valid && !move;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign ws = ott_pkg::is_ws(r_in_byte);

    // Next scan state and the tokens caused by the registered byte.
    always_comb begin
        n_mode      = r_mode;
        n_start_pos = r_start_pos;
        n_start_col = r_start_col;
        n_run_len   = r_run_len;
        n_dots      = r_dots;
        at_bound    = 1'b0;
        extend      = 1'b0;
        end_v       = 1'b0;
        end_kind    = ott_pkg::KIND_INVALID;
        slash_v     = 1'b0;

        // First, see whether the pending run ends at this byte.
        case (r_mode)
            ott_pkg::MODE_COMMENT: begin
                if (r_in_byte == ott_pkg::CH_LF) begin
                    end_v    = 1'b1;
                    end_kind = ott_pkg::KIND_COMMENT;
                    at_bound = 1'b1;
                end else begin
                    extend = 1'b1;
                end
            end
            ott_pkg::MODE_VF: begin
                if (r_in_byte == ott_pkg::CH_SPACE) begin
                    end_v    = 1'b1;
                    end_kind = ott_pkg::KIND_SYMBOL;
                    at_bound = 1'b1;
                end else if (ws) begin
                    end_v    = 1'b1;
                    at_bound = 1'b1;
                end else begin
                    n_mode = ott_pkg::MODE_INVALID;
                    extend = 1'b1;
                end
            end
            ott_pkg::MODE_DIGIT: begin
                // Tabs and CR stay inside a digit run.
                if (r_in_byte == ott_pkg::CH_SPACE || r_in_byte == ott_pkg::CH_LF ||
                    r_in_byte == ott_pkg::CH_SLASH) begin
                    end_v    = 1'b1;
                    end_kind = (r_dots == 2'd1) ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_NUMBER;
                    at_bound = 1'b1;
                end else begin
                    extend = 1'b1;
                end
            end
            ott_pkg::MODE_MINUS: begin
                if (ws) begin
                    end_v    = 1'b1;
                    end_kind = (r_dots == 2'd1) ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_INVALID;
                    at_bound = 1'b1;
                end else if (r_in_byte == ott_pkg::CH_SLASH && r_dots == 2'd1) begin
                    end_v    = 1'b1;
                    end_kind = ott_pkg::KIND_FLOAT;
                    at_bound = 1'b1;
                end else if (r_in_byte == ott_pkg::CH_SLASH) begin
                    n_mode = ott_pkg::MODE_INVALID;
                    extend = 1'b1;
                end else begin
                    extend = 1'b1;
                end
            end
            ott_pkg::MODE_INVALID: begin
                if (ws) begin
                    end_v    = 1'b1;
                    at_bound = 1'b1;
                end else begin
                    extend = 1'b1;
                end
            end
            default: begin
                at_bound = 1'b1;
            end
        endcase

        if (extend) begin
            if (r_run_len != '1) begin
                n_run_len = r_run_len + 1'b1;
            end
            if (r_in_byte == ott_pkg::CH_DOT && r_dots != 2'd2) begin
                n_dots = r_dots + 1'b1;
            end
        end

        // At a boundary the byte may open a new run or be a slash token on its own.
        // Stray whitespace emits nothing.
        if (at_bound) begin
            n_mode = ott_pkg::MODE_BOUND;
            if (r_in_byte == ott_pkg::CH_SLASH) begin
                slash_v = 1'b1;
            end else if (!ws) begin
                if (r_in_byte == ott_pkg::CH_HASH) begin
                    n_mode = ott_pkg::MODE_COMMENT;
                end else if (r_in_byte == ott_pkg::CH_LOW_V || r_in_byte == ott_pkg::CH_LOW_F) begin
                    n_mode = ott_pkg::MODE_VF;
                end else if (ott_pkg::is_digit(r_in_byte)) begin
                    n_mode = ott_pkg::MODE_DIGIT;
                end else if (r_in_byte == ott_pkg::CH_MINUS) begin
                    n_mode = ott_pkg::MODE_MINUS;
                end else begin
                    n_mode = ott_pkg::MODE_INVALID;
                end
                n_start_pos = r_pos;
                n_start_col = r_col;
                n_run_len   = {{(ott_pkg::LEN_W-1){1'b0}}, 1'b1};
                n_dots      = 2'd0;
            end
        end

        // The final byte flushes whatever run is still open.
        flush_v    = r_in_last && (n_mode != ott_pkg::MODE_BOUND);
        flush_kind = ott_pkg::KIND_INVALID;
        case (n_mode)
            ott_pkg::MODE_COMMENT: flush_kind = ott_pkg::KIND_COMMENT;
            ott_pkg::MODE_DIGIT:
                flush_kind = (n_dots == 2'd1) ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_NUMBER;
            ott_pkg::MODE_MINUS:
                flush_kind = (n_dots == 2'd1) ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_INVALID;
            default: flush_kind = ott_pkg::KIND_INVALID;
        endcase
    end

    // Saturating position counters.
    always_comb begin
        n_pos  = (r_pos != '1) ? r_pos + 1'b1 : r_pos;
        n_line = r_line;
        n_col  = r_col;
        if (r_in_byte == ott_pkg::CH_LF) begin
            if (r_line != '1) begin
                n_line = r_line + 1'b1;
            end
            n_col = {{(ott_pkg::COL_W-1){1'b0}}, 1'b1};
        end else if (r_col != '1) begin
            n_col = r_col + 1'b1;
        end
    end

    // Assemble the tokens and pack them in emission order; at most two are present.
    always_comb begin
        end_tok   = '{kind: end_kind, line: r_line, column: r_start_col,
                      offset: r_start_pos, length: r_run_len};
        slash_tok = '{kind: ott_pkg::KIND_SLASH, line: r_line, column: r_col, offset: r_pos,
                      length: {{(ott_pkg::LEN_W-1){1'b0}}, 1'b1}};
        flush_tok = '{kind: flush_kind, line: n_line, column: n_start_col,
                      offset: n_start_pos, length: n_run_len};
        slot0 = end_v ? end_tok : (slash_v ? slash_tok : flush_tok);
        slot1 = (end_v && slash_v) ? slash_tok : flush_tok;
        n_cnt = {1'b0, end_v} + {1'b0, slash_v} + {1'b0, flush_v};
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_cnt       <= 2'd0;
            r_mode      <= ott_pkg::MODE_BOUND;
            r_line      <= {{(ott_pkg::LINE_W-1){1'b0}}, 1'b1};
            r_col       <= {{(ott_pkg::COL_W-1){1'b0}}, 1'b1};
            r_pos       <= '0;
            r_start_pos <= '0;
            r_start_col <= {{(ott_pkg::COL_W-1){1'b0}}, 1'b1};
            r_run_len   <= '0;
            r_dots      <= 2'd0;
        end else begin
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move) begin
                r_cnt <= n_cnt;
            end else if (out_acc) begin
                r_cnt <= r_cnt - 2'd1;
            end

            if (move) begin
                if (r_in_last) begin
                    // End of stream: everything returns to its reset value.
                    r_mode      <= ott_pkg::MODE_BOUND;
                    r_line      <= {{(ott_pkg::LINE_W-1){1'b0}}, 1'b1};
                    r_col       <= {{(ott_pkg::COL_W-1){1'b0}}, 1'b1};
                    r_pos       <= '0;
                    r_start_pos <= '0;
                    r_start_col <= {{(ott_pkg::COL_W-1){1'b0}}, 1'b1};
                    r_run_len   <= '0;
                    r_dots      <= 2'd0;
                end else begin
                    r_mode      <= n_mode;
                    r_line      <= n_line;
                    r_col       <= n_col;
                    r_pos       <= n_pos;
                    r_start_pos <= n_start_pos;
                    r_start_col <= n_start_col;
                    r_run_len   <= n_run_len;
                    r_dots      <= n_dots;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_byte <= i_text_byte;
            r_in_last <= i_last_byte;
        end
        if (move) begin
            r_tok0 <= slot0;
            r_tok1 <= slot1;
        end else if (out_acc) begin
            r_tok0 <= r_tok1;
        end
    end

    assign o_out_valid    = (r_cnt != 2'd0);
    assign o_token_kind   = r_tok0.kind;
    assign o_token_line   = r_tok0.line;
    assign o_token_column = r_tok0.column;
    assign o_token_offset = r_tok0.offset;
    assign o_token_length = r_tok0.length;
    // The buffer only ever holds tokens of one byte, so the last one left closes it.
    assign o_last_of_item = (r_cnt == 2'd1);

`ifndef NO_ASSERTIONS
    // One byte never yields more than two tokens.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("result buffer overfilled");

    // A byte only moves on when the buffer has room for all its tokens.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !move)
        else $error("byte moved while two tokens were waiting");

    // The last byte of a stream restarts the position counters.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_last) |=> (r_pos == '0 && r_line == 24'd1 && r_col == 16'd1))
        else $error("counters not restarted after final byte");

    // Every emitted token covers at least one byte.
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_token_length != '0))
        else $error("token with zero length");
`endif

endmodule

[bench/obj_text_tokenizer_tb.sv]
// Self-checking bench for obj_text_tokenizer: a directed byte table, then random
// OBJ-like text checked against a predictor. Depends on ott_pkg and the RTL.
module obj_text_tokenizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     N_DIRECTED   = 27;
    localparam int     RANDOM_BYTES = 1070;
    localparam longint LIMIT_NS     = 64'd2_000_000;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam ott_pkg::t_token NO_TOKEN = '0;

    // One token as it is expected on the result port, with its last_of_item flag.
    typedef struct packed {
        ott_pkg::t_token tok;
        logic            last;
    } t_lexeme;

    // One row of the directed table. Where typed is set, tok is the single token that
    // the byte must produce, written out by hand; other rows go through the predictor.
    typedef struct packed {
        logic [7:0]      ch;
        logic            last;
        logic            typed;
        ott_pkg::t_token tok;
    } t_row;

    // The directed part walks through every token kind and the awkward corners:
    // a comment holding a high byte, a symbol, a minus float cut by a slash, a digit run
    // with a tab inside, a stray CR at a boundary, a letter followed by a tab, a minus
    // run that turns invalid at a slash, a number with two dots, a NUL byte, a pending
    // letter flushed by the last byte, and a lone high byte that is also the last byte.
    localparam t_row DIRECTED [N_DIRECTED] = '{
        '{ott_pkg::CH_HASH,  1'b0, 1'b0, NO_TOKEN},
        '{8'hFF,             1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_LF,    1'b0, 1'b1,
          '{ott_pkg::KIND_COMMENT, 24'd1, 16'd1, 32'd0, 16'd2}},
        '{ott_pkg::CH_LOW_V, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_SPACE, 1'b0, 1'b1,
          '{ott_pkg::KIND_SYMBOL, 24'd2, 16'd1, 32'd3, 16'd1}},
        '{ott_pkg::CH_MINUS, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_DOT,   1'b0, 1'b0, NO_TOKEN},
        '{"5",               1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_NINE,  1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_TAB,   1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_DOT,   1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_SPACE, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_CR,    1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_LOW_F, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_TAB,   1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_MINUS, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_TAB,   1'b0, 1'b0, NO_TOKEN},
        '{"1",               1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_DOT,   1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_DOT,   1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_SLASH, 1'b0, 1'b0, NO_TOKEN},
        '{8'h00,             1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_LF,    1'b0, 1'b0, NO_TOKEN},
        '{ott_pkg::CH_LOW_V, 1'b1, 1'b0, NO_TOKEN},
        '{8'h80,             1'b1, 1'b1,
          '{ott_pkg::KIND_INVALID, 24'd1, 16'd1, 32'd0, 16'd1}}
    };

    // Every input of the block starts at a known value.
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_text_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [2:0]  o_token_kind;
    logic [23:0] o_token_line;
    logic [15:0] o_token_column;
    logic [31:0] o_token_offset;
    logic [15:0] o_token_length;
    logic        o_last_of_item;

    obj_text_tokenizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_token_kind   (o_token_kind),
        .o_token_line   (o_token_line),
        .o_token_column (o_token_column),
        .o_token_offset (o_token_offset),
        .o_token_length (o_token_length),
        .o_last_of_item (o_last_of_item)
    );

    always #6 i_clk = ~i_clk;

    // Lexer state kept by the bench, advanced once per accepted request.
    ott_pkg::t_mode lex_mode = ott_pkg::MODE_BOUND;
    logic [23:0] cur_line  = 24'd1;
    logic [15:0] cur_col   = 16'd1;
    logic [31:0] cur_pos   = '0;
    logic [31:0] run_start = '0;
    logic [15:0] run_col   = 16'd1;
    logic [15:0] run_len   = '0;
    logic [1:0]  dots      = '0;

    ott_pkg::t_token step_tokens[$];   // tokens caused by the byte being lexed
    t_lexeme         token_queue[$];   // tokens still owed by the block, oldest first
    logic [7:0]      line_bytes[$];    // one generated line of random text

    bit          idle_on = 1'b0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          tokens_checked = 0;
    int          bytes_sent = 0;
    int          streams_flushed = 0;

    function automatic logic is_blank(input logic [7:0] b);
        return (b == ott_pkg::CH_SPACE) || (b >= ott_pkg::CH_TAB && b <= ott_pkg::CH_CR);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic reset_lexer();
        lex_mode  = ott_pkg::MODE_BOUND;
        cur_line  = 24'd1;
        cur_col   = 16'd1;
        cur_pos   = '0;
        run_start = '0;
        run_col   = 16'd1;
        run_len   = '0;
        dots      = '0;
    endtask

    // A token always carries the line count at the moment it is emitted.
    task automatic emit_token(input logic [2:0] kind, input logic [15:0] col,
                              input logic [31:0] off, input logic [15:0] len);
        ott_pkg::t_token t;
        t.kind   = kind;
        t.line   = cur_line;
        t.column = col;
        t.offset = off;
        t.length = len;
        step_tokens.push_back(t);
    endtask

    task automatic close_run(input logic [2:0] kind);
        emit_token(kind, run_col, run_start, run_len);
    endtask

    task automatic open_run(input ott_pkg::t_mode mode);
        lex_mode  = mode;
        run_start = cur_pos;
        run_col   = cur_col;
        run_len   = 16'd1;
        dots      = '0;
    endtask

    // Length saturates at its maximum; the dot count stops at two, meaning "several".
    task automatic grow_run(input logic [7:0] b);
        if (run_len != 16'hFFFF) run_len++;
        if (b == ott_pkg::CH_DOT && dots < 2'd2) dots++;
    endtask

    // Works out the tokens that one byte causes and leaves them in step_tokens.
    task automatic lex_byte(input logic [7:0] b, input logic last);
        logic at_bound;
        at_bound = 1'b0;
        step_tokens.delete();
        case (lex_mode)
            ott_pkg::MODE_COMMENT: begin
                if (b == ott_pkg::CH_LF) begin
                    close_run(ott_pkg::KIND_COMMENT);
                    at_bound = 1'b1;
                end else begin
                    grow_run(b);
                end
            end
            ott_pkg::MODE_VF: begin
                // Only a space makes the letter a symbol; other blanks make it invalid.
                if (b == ott_pkg::CH_SPACE) begin
                    close_run(ott_pkg::KIND_SYMBOL);
                    at_bound = 1'b1;
                end else if (is_blank(b)) begin
                    close_run(ott_pkg::KIND_INVALID);
                    at_bound = 1'b1;
                end else begin
                    lex_mode = ott_pkg::MODE_INVALID;
                    grow_run(b);
                end
            end
            ott_pkg::MODE_DIGIT: begin
                // Tabs and CR do not end a digit run.
                if (b == ott_pkg::CH_SPACE || b == ott_pkg::CH_LF ||
                    b == ott_pkg::CH_SLASH) begin
                    close_run(dots == 2'd1 ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_NUMBER);
                    at_bound = 1'b1;
                end else begin
                    grow_run(b);
                end
            end
            ott_pkg::MODE_MINUS: begin
                if (is_blank(b)) begin
                    close_run(dots == 2'd1 ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_INVALID);
                    at_bound = 1'b1;
                end else if (b == ott_pkg::CH_SLASH && dots == 2'd1) begin
                    close_run(ott_pkg::KIND_FLOAT);
                    at_bound = 1'b1;
                end else if (b == ott_pkg::CH_SLASH) begin
                    lex_mode = ott_pkg::MODE_INVALID;
                    grow_run(b);
                end else begin
                    grow_run(b);
                end
            end
            ott_pkg::MODE_INVALID: begin
                if (is_blank(b)) begin
                    close_run(ott_pkg::KIND_INVALID);
                    at_bound = 1'b1;
                end else begin
                    grow_run(b);
                end
            end
            default: at_bound = 1'b1;
        endcase

        // At a boundary the same byte may open a new run; stray blanks are skipped.
        if (at_bound) begin
            lex_mode = ott_pkg::MODE_BOUND;
            if (b == ott_pkg::CH_HASH) open_run(ott_pkg::MODE_COMMENT);
            else if (b == ott_pkg::CH_LOW_V || b == ott_pkg::CH_LOW_F)
                open_run(ott_pkg::MODE_VF);
            else if (b >= ott_pkg::CH_ZERO && b <= ott_pkg::CH_NINE)
                open_run(ott_pkg::MODE_DIGIT);
            else if (b == ott_pkg::CH_MINUS) open_run(ott_pkg::MODE_MINUS);
            else if (b == ott_pkg::CH_SLASH)
                emit_token(ott_pkg::KIND_SLASH, cur_col, cur_pos, 16'd1);
            else if (!is_blank(b)) open_run(ott_pkg::MODE_INVALID);
        end

        if (cur_pos != '1) cur_pos++;
        if (b == ott_pkg::CH_LF) begin
            if (cur_line != '1) cur_line++;
            cur_col = 16'd1;
        end else if (cur_col != '1) begin
            cur_col++;
        end

        // The last byte of a stream flushes whatever run is still open, then starts over.
        if (last) begin
            case (lex_mode)
                ott_pkg::MODE_COMMENT: close_run(ott_pkg::KIND_COMMENT);
                ott_pkg::MODE_VF, ott_pkg::MODE_INVALID: close_run(ott_pkg::KIND_INVALID);
                ott_pkg::MODE_DIGIT:
                    close_run(dots == 2'd1 ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_NUMBER);
                ott_pkg::MODE_MINUS:
                    close_run(dots == 2'd1 ? ott_pkg::KIND_FLOAT : ott_pkg::KIND_INVALID);
                default: ;
            endcase
            reset_lexer();
        end
    endtask

    // Offers one byte and returns in the time step of the edge that accepts it. The
    // caller is always at such an edge (or just past reset), so valid is either kept
    // high for the next request or lowered for a gap, never both in one step.
    task automatic send_byte(input logic [7:0] value, input logic last,
                             input logic typed, input ott_pkg::t_token typed_tok);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_text_byte <= value;
        i_last_byte <= last;
        // An unknown stall counts as a stall.
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        lex_byte(value, last);
        if (typed) begin
            step_tokens.delete();
            step_tokens.push_back(typed_tok);
        end
        foreach (step_tokens[k])
            token_queue.push_back('{tok: step_tokens[k], last: (k == step_tokens.size() - 1)});
        bytes_sent++;
        if (last) streams_flushed++;
    endtask

    // The sender stops until the block has delivered every token owed so far.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (token_queue.size() != 0);
    endtask

    task automatic add_digits(input int count);
        repeat (count) line_bytes.push_back(8'(ott_pkg::CH_ZERO + $urandom_range(0, 9)));
    endtask

    // Mostly a space between fields, now and then a tab to upset the symbol rule.
    function automatic logic [7:0] field_gap();
        return ($urandom_range(0, 7) == 0) ? ott_pkg::CH_TAB : ott_pkg::CH_SPACE;
    endfunction

    // Builds one line of text: well-formed vertex, face and comment lines with random
    // content most of the time, plus raw noise and fragments of the lexer's alphabet.
    task automatic build_line();
        int         kind;
        logic [7:0] b;
        int         pick;
        string      alphabet;
        alphabet = "vf#-./0123456789 \t\r\nxa";
        line_bytes.delete();
        kind = $urandom_range(0, 9);
        if (kind <= 3) begin
            line_bytes.push_back(ott_pkg::CH_LOW_V);
            repeat (3) begin
                line_bytes.push_back(field_gap());
                if ($urandom_range(0, 2) == 0) line_bytes.push_back(ott_pkg::CH_MINUS);
                add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 3) != 0) begin
                    line_bytes.push_back(ott_pkg::CH_DOT);
                    add_digits($urandom_range(0, 4));
                end
            end
            if ($urandom_range(0, 7) == 0) line_bytes.push_back(ott_pkg::CH_CR);
            line_bytes.push_back(ott_pkg::CH_LF);
        end else if (kind <= 6) begin
            line_bytes.push_back(ott_pkg::CH_LOW_F);
            repeat (3) begin
                line_bytes.push_back(field_gap());
                add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1) == 0) begin
                    line_bytes.push_back(ott_pkg::CH_SLASH);
                    if ($urandom_range(0, 1) == 0) add_digits($urandom_range(1, 2));
                    if ($urandom_range(0, 1) == 0) begin
                        line_bytes.push_back(ott_pkg::CH_SLASH);
                        add_digits($urandom_range(1, 2));
                    end
                end
            end
            line_bytes.push_back(ott_pkg::CH_LF);
        end else if (kind == 7) begin
            line_bytes.push_back(ott_pkg::CH_HASH);
            repeat ($urandom_range(0, 10)) begin
                do b = 8'($urandom_range(0, 255)); while (b == ott_pkg::CH_LF);
                line_bytes.push_back(b);
            end
            line_bytes.push_back(ott_pkg::CH_LF);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 12)) begin
                pick = $urandom_range(0, alphabet.len() + 1);
                if (pick == alphabet.len()) line_bytes.push_back(CH_VT);
                else if (pick == alphabet.len() + 1) line_bytes.push_back(CH_FF);
                else line_bytes.push_back(alphabet[pick]);
            end
        end
    endtask

    // Receiver side: stalls come in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (!i_rst_n || !idle_on) begin
            i_out_stall <= 1'b0;
            stall_left  <= 0;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Every token the block hands over is matched against the oldest one owed.
    always @(posedge i_clk) begin : token_check
        t_lexeme want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (token_queue.size() == 0) begin
                report_mismatch($sformatf("token with none owed: kind %0d offset %0d",
                                          o_token_kind, o_token_offset));
            end else begin
                want = token_queue.pop_front();
                tokens_checked++;
                if (o_token_kind !== want.tok.kind)
                    report_mismatch($sformatf("token %0d kind: got %0d, want %0d",
                                              tokens_checked, o_token_kind, want.tok.kind));
                if (o_token_line !== want.tok.line)
                    report_mismatch($sformatf("token %0d line: got %0d, want %0d",
                                              tokens_checked, o_token_line, want.tok.line));
                if (o_token_column !== want.tok.column)
                    report_mismatch($sformatf("token %0d column: got %0d, want %0d",
                                              tokens_checked, o_token_column,
                                              want.tok.column));
                if (o_token_offset !== want.tok.offset)
                    report_mismatch($sformatf("token %0d offset: got %0d, want %0d",
                                              tokens_checked, o_token_offset,
                                              want.tok.offset));
                if (o_token_length !== want.tok.length)
                    report_mismatch($sformatf("token %0d length: got %0d, want %0d",
                                              tokens_checked, o_token_length,
                                              want.tok.length));
                if (o_last_of_item !== want.last)
                    report_mismatch($sformatf("token %0d last_of_item: got %0b, want %0b",
                                              tokens_checked, o_last_of_item, want.last));
            end
        end
    end

    initial begin : stimulus
        int         random_start;
        bit         pressure_done;
        pressure_done = 1'b0;
        reset_lexer();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_on = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].tok);
        hold_until_drained();

        // Random text, line by line. Idling is switched per line so that stretches
        // without it appear, and it stays off over the closing part of the run.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            idle_on = (bytes_sent - random_start < RANDOM_BYTES - 150) &&
                      ($urandom_range(0, 3) != 0);
            if (!pressure_done && bytes_sent - random_start >= RANDOM_BYTES / 2) begin
                hold_until_drained();
                pressure_done = 1'b1;
            end
            build_line();
            foreach (line_bytes[k])
                send_byte(line_bytes[k], $urandom_range(0, 199) == 0, 1'b0, NO_TOKEN);
        end
        // A final newline that is also the last byte flushes anything still open.
        send_byte(ott_pkg::CH_LF, 1'b1, 1'b0, NO_TOKEN);
        i_in_valid <= 1'b0;

        while (token_queue.size() != 0) @(posedge i_clk);
        // Run on so that any extra token the block might add is caught.
        repeat (8) @(posedge i_clk);

        $display("Lexed %0d bytes: a directed table of %0d, then random OBJ-like lines.",
                 bytes_sent, N_DIRECTED);
        $display("Tokens matched: %0d; streams ended by last_byte: %0d; mismatches: %0d.",
                 tokens_checked, streams_flushed, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its longest.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("Run stopped by the watchdog with %0d tokens still owed.", token_queue.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
